@@ design/radix_digit_reencoder_defines.svh @@
// ----------------------------------------------------------------------------
// radix_digit_reencoder assertion macros
// Shared property wrappers for the radix_digit_reencoder checker; each use
// is sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_REENCODER_DEFINES_SVH
`define RADIX_DIGIT_REENCODER_DEFINES_SVH

// same-cycle implication
`define RDR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RDR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/rdr_pkg.sv @@
// ----------------------------------------------------------------------------
// rdr_pkg
// Field widths, opcodes and radix codes of the radix digit re-encoder.
// ----------------------------------------------------------------------------
package rdr_pkg;

	// port field widths
	localparam int OPCODE_W = 3;
	localparam int VALUE_W  = 32;
	localparam int RESULT_W = 32;

	// operation codes
	localparam logic [OPCODE_W-1:0] OP_TO_BIN     = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_BIN_TO_VAL = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_TO_OCT     = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_OCT_TO_VAL = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_BIN_TO_OCT = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_OCT_TO_BIN = 3'd5;

	// radix selector of one conversion pass
	typedef logic [1:0] rdx_t;
	localparam rdx_t RDX_2  = 2'd0;
	localparam rdx_t RDX_8  = 2'd1;
	localparam rdx_t RDX_10 = 2'd2;

endpackage

@@ design/radix_digit_reencoder.sv @@
// ----------------------------------------------------------------------------
// radix_digit_reencoder
// Converts between plain values and numbers whose decimal digits spell
// binary or octal digits, with wrap and an overflow flag.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata              | tuser
//  s_axis   | in  | [31:0] value       | [2:0] opcode
//  m_axis   | out | [31:0] result      | [0] overflow
//
//  One item at a time through a shared digit unit. A pass runs a load step,
//  double-dabble steps over the DATA_WIDTH bits when the input radix is ten,
//  a digit step per input digit plus an end-of-digits step, and a finish step;
//  composed opcodes run two passes, then an output step. An unused opcode goes
//  straight to the output step. s_axis_tready is high only while the sequencer
//  is idle; a finished result waits for a free output register. Reset clears
//  the sequencer and m_axis_tvalid.
// ----------------------------------------------------------------------------
module radix_digit_reencoder #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [rdr_pkg::VALUE_W-1:0]   s_axis_tdata,   // [31:0] value
	input  logic [rdr_pkg::OPCODE_W-1:0]  s_axis_tuser,   // [2:0] opcode
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [rdr_pkg::RESULT_W-1:0]  m_axis_tdata,   // [31:0] result
	output logic [0:0]                    m_axis_tuser    // [0] overflow
);
	import rdr_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int EW = DW + 1;
	localparam int XW = DW + 5;
	localparam int ND = (DW * 30103) / 100000 + 1;
	localparam int BW = 4 * ND;
	localparam int CW = $clog2(DW);
	localparam int MW = (DW > VALUE_W) ? DW : VALUE_W;

	localparam logic [EW-1:0] HALF = EW'(1) << (DW - 1);
	localparam logic [EW-1:0] LIM  = HALF + EW'(1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOAD   = 3'd1;
	localparam logic [2:0] ST_DABBLE = 3'd2;
	localparam logic [2:0] ST_DIGIT  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	logic [2:0]    state_q;
	logic          pass2_q;
	logic          m_valid_q;
	rdx_t          in_rdx_q, out_rdx_q, in2_q, out2_q;
	logic [DW-1:0] word_q, mag_q, low_q, pw_q, res_q;
	logic [BW-1:0] bcd_q;
	logic [EW-1:0] exact_q, pwcap_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q, ovf_q;
	logic [RESULT_W-1:0] m_data_q;
	logic          m_user_q;

	logic          s_fire, out_free, op_ok, src_zero, pass_ovf;
	logic [MW-1:0] val_ext, res_ext;
	rdx_t          p1_in, p1_out, p2_in, p2_out;
	logic          p1_only;
	logic [3:0]    dig, rad_val;
	logic [XW-1:0] prod_low, prod_ex, sum_ex, prod_cap;
	logic [EW-1:0] term_ex;
	logic [DW-1:0] pw_nxt, res_nxt;
	logic [BW-1:0] bcd_adj;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	assign val_ext = MW'(s_axis_tdata);
	assign res_ext = MW'(res_q);
	assign op_ok   = s_axis_tuser inside {[OP_TO_BIN:OP_OCT_TO_BIN]};

	// map opcode to the radix pair of each pass
	always_comb begin
		p1_in   = RDX_10;
		p1_out  = RDX_2;
		p2_in   = RDX_8;
		p2_out  = RDX_10;
		p1_only = 1'b1;
		case (s_axis_tuser)
			OP_TO_BIN: begin
				p1_in  = RDX_2;
				p1_out = RDX_10;
			end
			OP_BIN_TO_VAL: begin
				p1_in  = RDX_10;
				p1_out = RDX_2;
			end
			OP_TO_OCT: begin
				p1_in  = RDX_8;
				p1_out = RDX_10;
			end
			OP_OCT_TO_VAL: begin
				p1_in  = RDX_10;
				p1_out = RDX_8;
			end
			OP_BIN_TO_OCT: begin
				p1_in   = RDX_10;
				p1_out  = RDX_2;
				p2_in   = RDX_8;
				p2_out  = RDX_10;
				p1_only = 1'b0;
			end
			OP_OCT_TO_BIN: begin
				p1_in   = RDX_10;
				p1_out  = RDX_8;
				p2_in   = RDX_2;
				p2_out  = RDX_10;
				p1_only = 1'b0;
			end
			default: begin
				p1_only = 1'b1;
			end
		endcase
	end

	// pick the next input digit and check for an exhausted source
	always_comb begin
		case (in_rdx_q)
			RDX_2: begin
				dig      = {3'b000, mag_q[0]};
				src_zero = (mag_q == '0);
			end
			RDX_8: begin
				dig      = {1'b0, mag_q[2:0]};
				src_zero = (mag_q == '0);
			end
			default: begin
				dig      = bcd_q[3:0];
				src_zero = (bcd_q == '0);
			end
		endcase
	end

	// advance the wrapped output power and pick the radix for the saturated power
	always_comb begin
		case (out_rdx_q)
			RDX_2: begin
				rad_val = 4'd2;
				pw_nxt  = pw_q << 1;
			end
			RDX_8: begin
				rad_val = 4'd8;
				pw_nxt  = pw_q << 3;
			end
			default: begin
				rad_val = 4'd10;
				pw_nxt  = (pw_q << 3) + (pw_q << 1);
			end
		endcase
	end

	// shared digit unit: low word, saturated exact sum, saturated power
	always_comb begin
		prod_low = XW'(dig) * XW'(pw_q);
		prod_ex  = XW'(dig) * XW'(pwcap_q);
		term_ex  = (prod_ex > XW'(LIM)) ? LIM : prod_ex[EW-1:0];
		sum_ex   = XW'(exact_q) + XW'(term_ex);
		prod_cap = XW'(rad_val) * XW'(pwcap_q);
	end

	// add three to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	// finish a pass: overflow test and sign restore
	assign pass_ovf = neg_q ? (exact_q > HALF) : (exact_q >= HALF);
	assign res_nxt  = neg_q ? (DW'(0) - low_q) : low_q;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pass2_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// raise valid as a result moves out, drop it once the beat is taken
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						pass2_q <= op_ok && !p1_only;
						state_q <= op_ok ? ST_LOAD : ST_OUT;
					end
				end
				ST_LOAD: begin
					state_q <= (in_rdx_q == RDX_10) ? ST_DABBLE : ST_DIGIT;
				end
				ST_DABBLE: begin
					if (cnt_q == CW'(DW - 1)) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (src_zero) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					pass2_q <= 1'b0;
					state_q <= pass2_q ? ST_LOAD : ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					word_q    <= val_ext[DW-1:0];
					in_rdx_q  <= p1_in;
					out_rdx_q <= p1_out;
					in2_q     <= p2_in;
					out2_q    <= p2_out;
					ovf_q     <= 1'b0;
					res_q     <= '0;
				end
			end
			ST_LOAD: begin
				neg_q   <= word_q[DW-1];
				mag_q   <= word_q[DW-1] ? (DW'(0) - word_q) : word_q;
				low_q   <= '0;
				pw_q    <= DW'(1);
				exact_q <= '0;
				pwcap_q <= EW'(1);
				bcd_q   <= '0;
				cnt_q   <= '0;
			end
			ST_DABBLE: begin
				bcd_q <= {bcd_adj[BW-2:0], mag_q[DW-1]};
				mag_q <= mag_q << 1;
				cnt_q <= cnt_q + CW'(1);
			end
			ST_DIGIT: begin
				if (!src_zero) begin
					low_q   <= low_q + prod_low[DW-1:0];
					exact_q <= (sum_ex > XW'(LIM)) ? LIM : sum_ex[EW-1:0];
					pw_q    <= pw_nxt;
					pwcap_q <= (prod_cap > XW'(LIM)) ? LIM : prod_cap[EW-1:0];
					case (in_rdx_q)
						RDX_2:   mag_q <= mag_q >> 1;
						RDX_8:   mag_q <= mag_q >> 3;
						default: bcd_q <= bcd_q >> 4;
					endcase
				end
			end
			ST_FINISH: begin
				ovf_q  <= ovf_q | pass_ovf;
				res_q  <= res_nxt;
				word_q <= res_nxt;
				if (pass2_q) begin
					in_rdx_q  <= in2_q;
					out_rdx_q <= out2_q;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					m_data_q <= res_ext[RESULT_W-1:0];
					m_user_q <= ovf_q;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

endmodule

@@ design/rdr_checker.sv @@
// ----------------------------------------------------------------------------
// rdr_checker
// Port-level checks of the radix digit re-encoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "radix_digit_reencoder_defines.svh"

module rdr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [rdr_pkg::VALUE_W-1:0]   s_axis_tdata,
	input  logic [rdr_pkg::OPCODE_W-1:0]  s_axis_tuser,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [rdr_pkg::RESULT_W-1:0]  m_axis_tdata,
	input  logic [0:0]                    m_axis_tuser
);
	import rdr_pkg::*;

	logic [1:0] pending_q;
	logic       s_fire, m_fire;

	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;

	// count items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else begin
			case ({s_fire, m_fire})
				2'b10:   pending_q <= pending_q + 2'd1;
				2'b01:   pending_q <= pending_q - 2'd1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	`RDR_ASSERT_NXT(a_busy_after_accept, s_fire, !s_axis_tready,
		"input accepted again in the cycle after an accept")
	`RDR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"stalled result beat changed")
	`RDR_ASSERT_IMP(a_no_phantom, m_axis_tvalid, pending_q != 2'd0,
		"result beat with no item outstanding")
	`RDR_ASSERT_IMP(a_one_in_flight, s_axis_tready,
		pending_q != 2'd2 && pending_q != 2'd3,
		"ready while an item is still converting")

endmodule

bind radix_digit_reencoder rdr_checker u_rdr_checker (.*);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: radix_digit_reencoder testbench
// Drives opcode/value beats on s_axis and checks every m_axis beat against a
// local digit re-encoding predictor. A directed table hits extremes, every
// opcode, unchecked digits, wrap with overflow and the unused opcodes; random
// bursts follow with a stalling receiver, one long output hold-off and one
// full drain pause.
// ----------------------------------------------------------------------------
module tb;

	import rdr_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

	localparam int NUM_DIRECTED   = 24;
	localparam int NUM_RANDOM     = 1300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 500;
	localparam int HOLD_AT_ITEM   = 400;
	localparam int DRAIN_AT_ITEM  = 700;
	localparam int TAIL_CYCLES    = 120;

	typedef struct packed {
		logic [RESULT_W-1:0] result;
		logic                ovf;
	} conv_result_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [VALUE_W-1:0]  val;
		bit                  typed;
		logic [RESULT_W-1:0] res;
		logic                ovf;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [VALUE_W-1:0]   s_axis_tdata;
	logic [OPCODE_W-1:0]  s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [RESULT_W-1:0]  m_axis_tdata;
	logic [0:0]           m_axis_tuser;

	conv_result_t pending_results[$];
	int           fail_cnt = 0;
	int           sent_cnt = 0;
	bit           hold_done = 0;

	// directed stimulus; typed rows carry an expectation read straight off the spec
	stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
		'{OP_TO_BIN,     32'd0,           1'b1, 32'd0,           1'b0},
		'{OP_TO_BIN,     32'd1,           1'b1, 32'd1,           1'b0},
		'{OP_TO_BIN,     32'hFFFF_FFFF,   1'b1, 32'hFFFF_FFFF,   1'b0},
		'{OP_TO_BIN,     32'd1023,        1'b0, 32'd0,           1'b0},
		'{OP_TO_BIN,     32'd1024,        1'b0, 32'd0,           1'b0},
		'{OP_TO_BIN,     32'h7FFF_FFFF,   1'b0, 32'd0,           1'b0},
		'{OP_TO_BIN,     32'h8000_0000,   1'b0, 32'd0,           1'b0},
		'{OP_BIN_TO_VAL, 32'd1010,        1'b1, 32'd10,          1'b0},
		'{OP_BIN_TO_VAL, 32'hFFFF_FC0E,   1'b1, 32'hFFFF_FFF6,   1'b0},
		'{OP_BIN_TO_VAL, 32'd1021,        1'b0, 32'd0,           1'b0},
		'{OP_BIN_TO_VAL, 32'h7FFF_FFFF,   1'b0, 32'd0,           1'b0},
		'{OP_BIN_TO_VAL, 32'h8000_0000,   1'b0, 32'd0,           1'b0},
		'{OP_TO_OCT,     32'd8,           1'b1, 32'd10,          1'b0},
		'{OP_TO_OCT,     32'h7FFF_FFFF,   1'b0, 32'd0,           1'b0},
		'{OP_TO_OCT,     32'h8000_0000,   1'b0, 32'd0,           1'b0},
		'{OP_OCT_TO_VAL, 32'd17,          1'b1, 32'd15,          1'b0},
		'{OP_OCT_TO_VAL, 32'd99,          1'b0, 32'd0,           1'b0},
		'{OP_OCT_TO_VAL, 32'h8000_0000,   1'b0, 32'd0,           1'b0},
		'{OP_BIN_TO_OCT, 32'd1010,        1'b1, 32'd12,          1'b0},
		'{OP_BIN_TO_OCT, 32'h7FFF_FFFF,   1'b0, 32'd0,           1'b0},
		'{OP_OCT_TO_BIN, 32'd17,          1'b1, 32'd1111,        1'b0},
		'{OP_OCT_TO_BIN, 32'h8000_0000,   1'b0, 32'd0,           1'b0},
		'{OP_SPARE_6,    32'd123,         1'b1, 32'd0,           1'b0},
		'{OP_SPARE_7,    32'hFFFF_FFFB,   1'b1, 32'd0,           1'b0}
	};

	radix_digit_reencoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// product clamped to a ceiling
	function automatic longint unsigned clamp_mul(input longint unsigned a,
			input longint unsigned b, input longint unsigned ceiling);
		if (a != 0 && b > ceiling / a)
			return ceiling;
		return (a * b > ceiling) ? ceiling : a * b;
	endfunction

	// one pass: peel digits in radix rin, weigh them by powers of rout
	function automatic logic [31:0] digit_pass(input logic [31:0] word,
			input longint unsigned rin, input longint unsigned rout, output bit ovf);
		longint unsigned half, ceiling, mag, low, pw, exact, pw_cap, d, term;
		bit neg;
		half    = 64'd1 << 31;
		ceiling = half + 1;
		neg     = word[31];
		mag     = neg ? {32'd0, ~word + 32'd1} : {32'd0, word};
		low     = 0;
		pw      = 1;
		exact   = 0;
		pw_cap  = 1;
		while (mag != 0) begin
			d    = mag % rin;
			mag  = mag / rin;
			low  = low + d * pw;
			term = clamp_mul(d, pw_cap, ceiling);
			if (exact > ceiling - term)
				exact = ceiling;
			else
				exact = exact + term;
			pw     = pw * rout;
			pw_cap = clamp_mul(pw_cap, rout, ceiling);
		end
		ovf = neg ? (exact > half) : (exact > half - 1);
		return neg ? (32'd0 - low[31:0]) : low[31:0];
	endfunction

	// expected result of one opcode/value beat
	function automatic conv_result_t reencode(input logic [OPCODE_W-1:0] op,
			input logic [VALUE_W-1:0] val);
		conv_result_t r;
		logic [31:0]  mid;
		bit           o1, o2;
		o1 = 0;
		o2 = 0;
		case (op)
			OP_TO_BIN:     r.result = digit_pass(val, 2, 10, o1);
			OP_BIN_TO_VAL: r.result = digit_pass(val, 10, 2, o1);
			OP_TO_OCT:     r.result = digit_pass(val, 8, 10, o1);
			OP_OCT_TO_VAL: r.result = digit_pass(val, 10, 8, o1);
			OP_BIN_TO_OCT: begin
				mid      = digit_pass(val, 10, 2, o1);
				r.result = digit_pass(mid, 8, 10, o2);
			end
			OP_OCT_TO_BIN: begin
				mid      = digit_pass(val, 10, 8, o1);
				r.result = digit_pass(mid, 2, 10, o2);
			end
			default: r.result = '0;
		endcase
		r.ovf = o1 | o2;
		return r;
	endfunction

	// decimal number spelled with digits 0..top_digit, wrapped to 32 bits
	function automatic logic [31:0] digit_word(input int unsigned top_digit,
			input int unsigned ndig);
		longint unsigned acc;
		acc = 0;
		for (int k = 0; k < ndig; k++)
			acc = acc * 10 + $urandom_range(0, top_digit);
		return acc[31:0];
	endfunction

	// random operand, in three draws out of ten a well-formed digit string for the digit opcodes
	function automatic logic [31:0] pick_value(input logic [OPCODE_W-1:0] op);
		logic [31:0] v;
		int unsigned kind;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2: v = $urandom;
			3, 4:    v = $urandom_range(0, 4095);
			5, 6, 7: begin
				if (op == OP_BIN_TO_VAL || op == OP_BIN_TO_OCT)
					v = digit_word(1, $urandom_range(1, 11));
				else if (op == OP_OCT_TO_VAL || op == OP_OCT_TO_BIN)
					v = digit_word(7, $urandom_range(1, 10));
				else if (op == OP_TO_BIN)
					v = $urandom_range(0, 1 << $urandom_range(1, 12));
				else
					v = $urandom_range(0, 1 << $urandom_range(1, 30));
			end
			8: v = digit_word(9, $urandom_range(1, 10));
			default: begin
				case ($urandom_range(0, 4))
					0:       v = 32'd0;
					1:       v = 32'd1;
					2:       v = 32'hFFFF_FFFF;
					3:       v = 32'h7FFF_FFFF;
					default: v = 32'h8000_0000;
				endcase
			end
		endcase
		if (kind >= 3 && kind <= 8 && $urandom_range(0, 3) == 0)
			v = -v;
		return v;
	endfunction

	// offer one beat, hold it until accepted, then queue its expectation
	task automatic offer_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
			input bit typed, input conv_result_t want);
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = op;
		s_axis_tdata  = val;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(typed ? want : reencode(op, val));
		sent_cnt++;
	endtask

	// drop valid, scrambling the idle data
	task automatic idle_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			s_axis_tdata  = $urandom;
			s_axis_tuser  = OPCODE_W'($urandom);
		end
	endtask

	// hold off until every queued result has come back
	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// stimulus and end of run
	initial begin
		logic [OPCODE_W-1:0] op;
		int                  burst;
		int                  n;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		arst_n        = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			offer_item(directed_rows[i].op, directed_rows[i].val, directed_rows[i].typed,
				'{directed_rows[i].res, directed_rows[i].ovf});
			idle_sender($urandom_range(0, 2));
		end
		idle_sender(1);
		wait_drained();

		n = 0;
		while (n < NUM_RANDOM) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && n < NUM_RANDOM; k++) begin
				if ($urandom_range(0, 15) < 14)
					op = OPCODE_W'($urandom_range(0, 5));
				else
					op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
				offer_item(op, pick_value(op), 1'b0, '0);
				n++;
				if (n == DRAIN_AT_ITEM) begin
					idle_sender(1);
					wait_drained();
				end
			end
			if ($urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 10));
		end
		idle_sender(1);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("** radix_digit_reencoder: PASSED **");
		else
			$display("** radix_digit_reencoder: FAILED **");
		$finish;
	end

	// receiver: stall pattern in runs of random length, plus one long hold-off
	initial begin
		int mode;
		int run_len;
		int phase;
		m_axis_tready = 1'b0;
		phase = 0;
		wait (arst_n);
		forever begin
			mode    = $urandom_range(0, 3);
			run_len = $urandom_range(20, 200);
			repeat (run_len) begin
				@(negedge clk);
				if (!hold_done && sent_cnt >= HOLD_AT_ITEM) begin
					hold_done     = 1'b1;
					m_axis_tready = 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				phase++;
				case (mode)
					0:       m_axis_tready = 1'b1;
					1:       m_axis_tready = 1'($urandom_range(0, 1));
					2:       m_axis_tready = ($urandom_range(0, 7) == 0);
					default: m_axis_tready = (phase % 5 != 0) && (phase % 5 != 3);
				endcase
			end
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		conv_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual %h ovf %b",
					$time, m_axis_tdata, m_axis_tuser[0]);
				fail_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata !== want.result) begin
					$display("%0t: result mismatch: expected %h, actual %h",
						$time, want.result, m_axis_tdata);
					fail_cnt++;
				end
				if (m_axis_tuser[0] !== want.ovf) begin
					$display("%0t: overflow mismatch: expected %b, actual %b",
						$time, want.ovf, m_axis_tuser[0]);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog: end the run after too many cycles with no beat on either side
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: watchdog expired with %0d results outstanding",
			$time, pending_results.size());
		$display("** radix_digit_reencoder: FAILED **");
		$finish;
	end

endmodule
